### hw/rtl/cau_pkg.sv
// Package for the complex arithmetic unit: operation codes and the input and
// result word types. No dependencies.
package cau_pkg;

  typedef enum logic [2:0] {
    OP_ADD   = 3'd0,
    OP_SUB   = 3'd1,
    OP_SCALE = 3'd2,
    OP_MUL   = 3'd3,
    OP_CONJ  = 3'd4,
    OP_MAGSQ = 3'd5,
    OP_RECIP = 3'd6,
    OP_DIV   = 3'd7
  } op_t;

  typedef struct packed {
    op_t                action;
    logic signed [15:0] a_re;
    logic signed [15:0] a_im;
    logic signed [15:0] b_re;
    logic signed [15:0] b_im;
    logic signed [15:0] scale_factor;
  } in_word_t;

  typedef struct packed {
    logic signed [15:0] z_re;
    logic signed [15:0] z_im;
    logic               saturated;
    logic               divide_by_zero;
  } out_word_t;

endpackage

### hw/rtl/complex_arithmetic_unit.sv
// Complex arithmetic unit on signed fixed-point operands, saturating results.
// Stages: the product register loads at the accept edge, then the sums
// register, four 4-bit radix-2 divider stages and the sign/clip output
// register.
// Throughput: one word per cycle; the whole pipeline advances together and
// holds while the output word waits.
// Reset: rst_n (synchronous, active low) clears all stage valid bits.
// Depends on cau_pkg.
module complex_arithmetic_unit #(
  parameter int FRAC_BITS = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  cau_pkg::in_word_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output cau_pkg::out_word_t out_data
);

  localparam int NW = ((33 + FRAC_BITS) > (16 + 2 * FRAC_BITS)) ?
                      (33 + FRAC_BITS) : (16 + 2 * FRAC_BITS);
  localparam int RW = ((NW > 48) ? NW : 48) + 1;
  localparam int NDS = 4;

  typedef struct packed {
    logic               isdiv;
    logic               dz;
    logic               neg_re;
    logic               neg_im;
    logic               ovf_re;
    logic               ovf_im;
    logic [31:0]        d;
    logic [RW-1:0]      rem_re;
    logic [RW-1:0]      rem_im;
    logic [15:0]        q_re;
    logic [15:0]        q_im;
    logic signed [33:0] raw_re;
    logic signed [33:0] raw_im;
  } pipe_t;

  logic en;

  // ---------------- stage 1: products ----------------
  logic                s1_vld_r;
  cau_pkg::op_t        s1_op_r;
  logic signed [15:0]  s1_ar_r, s1_ai_r, s1_br_r, s1_bi_r;
  logic signed [31:0]  s1_p_r [6];
  logic signed [15:0]  m_x [6];
  logic signed [15:0]  m_y [6];

  always_comb begin
    m_x[0] = in_data.a_re;
    m_y[0] = (in_data.action == cau_pkg::OP_SCALE) ? in_data.scale_factor : in_data.b_re;
    m_x[1] = in_data.a_im;
    m_y[1] = (in_data.action == cau_pkg::OP_SCALE) ? in_data.scale_factor : in_data.b_im;
    m_x[2] = in_data.a_re;
    m_y[2] = in_data.b_im;
    m_x[3] = in_data.a_im;
    m_y[3] = in_data.b_re;
    m_x[4] = (in_data.action == cau_pkg::OP_DIV) ? in_data.b_re : in_data.a_re;
    m_y[4] = m_x[4];
    m_x[5] = (in_data.action == cau_pkg::OP_DIV) ? in_data.b_im : in_data.a_im;
    m_y[5] = m_x[5];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (en) begin
      s1_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_op_r <= in_data.action;
      s1_ar_r <= in_data.a_re;
      s1_ai_r <= in_data.a_im;
      s1_br_r <= in_data.b_re;
      s1_bi_r <= in_data.b_im;
      for (int i = 0; i < 6; i++) begin
        s1_p_r[i] <= m_x[i] * m_y[i];
      end
    end
  end

  // ---------------- stage 2: sums, numerators, divisor ----------------
  logic signed [32:0]   sum01, dif01, dif32, sum23, sum45;
  logic signed [31:0]   scl_re, scl_im;
  logic signed [NW-1:0] nre_s, nim_s;
  logic signed [NW-1:0] nre_neg, nim_neg;
  logic [32:0]          dsum;
  pipe_t                s2_nxt;

  always_comb begin
    sum01   = 33'(s1_p_r[0]) + 33'(s1_p_r[1]);
    dif01   = 33'(s1_p_r[0]) - 33'(s1_p_r[1]);
    dif32   = 33'(s1_p_r[3]) - 33'(s1_p_r[2]);
    sum23   = 33'(s1_p_r[2]) + 33'(s1_p_r[3]);
    sum45   = 33'(s1_p_r[4]) + 33'(s1_p_r[5]);
    scl_re  = s1_p_r[0] >>> FRAC_BITS;
    scl_im  = s1_p_r[1] >>> FRAC_BITS;
    dsum    = 33'(sum45);
    if (s1_op_r == cau_pkg::OP_RECIP) begin
      nre_s = NW'(s1_ar_r) <<< (2 * FRAC_BITS);
      nim_s = -(NW'(s1_ai_r) <<< (2 * FRAC_BITS));
    end else begin
      nre_s = NW'(sum01) <<< FRAC_BITS;
      nim_s = NW'(dif32) <<< FRAC_BITS;
    end
    nre_neg = -nre_s;
    nim_neg = -nim_s;

    s2_nxt        = '0;
    s2_nxt.isdiv  = (s1_op_r == cau_pkg::OP_RECIP) || (s1_op_r == cau_pkg::OP_DIV);
    s2_nxt.d      = dsum[31:0];
    s2_nxt.dz     = s2_nxt.isdiv && (dsum == '0);
    s2_nxt.neg_re = nre_s[NW-1];
    s2_nxt.neg_im = nim_s[NW-1];
    s2_nxt.rem_re = RW'(nre_s[NW-1] ? unsigned'(nre_neg) : unsigned'(nre_s));
    s2_nxt.rem_im = RW'(nim_s[NW-1] ? unsigned'(nim_neg) : unsigned'(nim_s));
    case (s1_op_r)
      cau_pkg::OP_ADD: begin
        s2_nxt.raw_re = 34'(s1_ar_r) + 34'(s1_br_r);
        s2_nxt.raw_im = 34'(s1_ai_r) + 34'(s1_bi_r);
      end
      cau_pkg::OP_SUB: begin
        s2_nxt.raw_re = 34'(s1_ar_r) - 34'(s1_br_r);
        s2_nxt.raw_im = 34'(s1_ai_r) - 34'(s1_bi_r);
      end
      cau_pkg::OP_SCALE: begin
        s2_nxt.raw_re = 34'(scl_re);
        s2_nxt.raw_im = 34'(scl_im);
      end
      cau_pkg::OP_MUL: begin
        s2_nxt.raw_re = 34'(dif01 >>> FRAC_BITS);
        s2_nxt.raw_im = 34'(sum23 >>> FRAC_BITS);
      end
      cau_pkg::OP_CONJ: begin
        s2_nxt.raw_re = 34'(s1_ar_r);
        s2_nxt.raw_im = -34'(s1_ai_r);
      end
      cau_pkg::OP_MAGSQ: begin
        s2_nxt.raw_re = 34'(sum45 >>> FRAC_BITS);
        s2_nxt.raw_im = '0;
      end
      default: begin
        s2_nxt.raw_re = '0;
        s2_nxt.raw_im = '0;
      end
    endcase
  end

  // ---------------- divider stages: 4 quotient bits each ----------------
  logic  st_vld_r [NDS+1];
  pipe_t st_r     [NDS+1];
  pipe_t st_nxt   [NDS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_vld_r[0] <= 1'b0;
    end else if (en) begin
      st_vld_r[0] <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st_r[0] <= s2_nxt;
    end
  end

  for (genvar k = 0; k < NDS; k++) begin : g_div
    localparam int Base = 12 - 4 * k;

    always_comb begin
      logic [RW-1:0] dsh;
      logic [RW-1:0] dtop;
      st_nxt[k] = st_r[k];
      dtop = RW'({st_r[k].d, 16'b0});
      if (k == 0) begin
        // quotient of 2^16 or more saturates whatever the sign
        st_nxt[k].ovf_re = (st_r[k].rem_re >= dtop);
        st_nxt[k].ovf_im = (st_r[k].rem_im >= dtop);
      end
      for (int i = 3; i >= 0; i--) begin
        dsh = RW'(st_r[k].d) << (Base + i);
        if (st_nxt[k].rem_re >= dsh) begin
          st_nxt[k].rem_re = st_nxt[k].rem_re - dsh;
          st_nxt[k].q_re   = {st_nxt[k].q_re[14:0], 1'b1};
        end else begin
          st_nxt[k].q_re   = {st_nxt[k].q_re[14:0], 1'b0};
        end
        if (st_nxt[k].rem_im >= dsh) begin
          st_nxt[k].rem_im = st_nxt[k].rem_im - dsh;
          st_nxt[k].q_im   = {st_nxt[k].q_im[14:0], 1'b1};
        end else begin
          st_nxt[k].q_im   = {st_nxt[k].q_im[14:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        st_vld_r[k+1] <= 1'b0;
      end else if (en) begin
        st_vld_r[k+1] <= st_vld_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        st_r[k+1] <= st_nxt[k];
      end
    end
  end

  // ---------------- output stage: sign, clip, select ----------------
  pipe_t              fin;
  logic signed [33:0] v_re, v_im;
  logic               sat_re, sat_im;
  cau_pkg::out_word_t out_nxt;
  cau_pkg::out_word_t out_data_r;
  logic               out_valid_r;

  always_comb begin
    fin = st_r[NDS];
    if (!fin.isdiv) begin
      v_re = fin.raw_re;
      v_im = fin.raw_im;
    end else begin
      if (fin.ovf_re) begin
        v_re = fin.neg_re ? -34'sd65536 : 34'sd65536;
      end else begin
        v_re = fin.neg_re ? -34'(fin.q_re) : 34'(fin.q_re);
      end
      if (fin.ovf_im) begin
        v_im = fin.neg_im ? -34'sd65536 : 34'sd65536;
      end else begin
        v_im = fin.neg_im ? -34'(fin.q_im) : 34'(fin.q_im);
      end
    end
    sat_re = (v_re > 34'sd32767) || (v_re < -34'sd32768);
    sat_im = (v_im > 34'sd32767) || (v_im < -34'sd32768);
    out_nxt.z_re = (v_re > 34'sd32767) ? 16'sh7fff :
                   (v_re < -34'sd32768) ? 16'sh8000 : v_re[15:0];
    out_nxt.z_im = (v_im > 34'sd32767) ? 16'sh7fff :
                   (v_im < -34'sd32768) ? 16'sh8000 : v_im[15:0];
    out_nxt.saturated      = sat_re || sat_im;
    out_nxt.divide_by_zero = fin.dz;
    if (fin.dz) begin
      out_nxt.z_re      = '0;
      out_nxt.z_im      = '0;
      out_nxt.saturated = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= st_vld_r[NDS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r <= out_nxt;
    end
  end

  // advance everything unless the output word is stuck
  assign en        = !out_valid_r || out_ready;
  assign in_ready  = en;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // ---------------- assertions ----------------
  a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.divide_by_zero |->
      (out_data_r.z_re == 16'sd0) && (out_data_r.z_im == 16'sd0) && !out_data_r.saturated)
    else $error("divide by zero word carries nonzero payload");

  a_sat_rail: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.saturated |->
      (out_data_r.z_re == 16'sh7fff) || (out_data_r.z_re == 16'sh8000) ||
      (out_data_r.z_im == 16'sh7fff) || (out_data_r.z_im == 16'sh8000))
    else $error("saturated flag without a clipped part");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(st_vld_r[NDS]) && $stable(s1_vld_r))
    else $error("pipeline moved during stall");

endmodule

### dv/complex_arithmetic_unit_tb.sv
// Testbench for complex_arithmetic_unit: a directed table, then random words,
// each checked against a typed-in table result or a local predictor of the complex operations.
// Depends on cau_pkg and the complex_arithmetic_unit RTL.
`timescale 1ns / 1ps

module complex_arithmetic_unit_tb;

  localparam int FRAC = 8;
  localparam int N_RANDOM = 1800;
  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 20;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  cau_pkg::in_word_t  in_data = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  cau_pkg::out_word_t out_data;

  complex_arithmetic_unit #(.FRAC_BITS(FRAC)) DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  cau_pkg::out_word_t pending_results[$];
  int                 n_fail = 0;
  int                 cycle_count = 0;
  bit                 quiet = 1'b0;

  function automatic logic signed [63:0] floor_q(input logic signed [63:0] v);
    return v >>> FRAC;
  endfunction

  function automatic cau_pkg::out_word_t complex_result(input cau_pkg::in_word_t w);
    logic signed [63:0] ar, ai, br, bi, k, re, im, d, one;
    cau_pkg::out_word_t r;
    ar = w.a_re; ai = w.a_im; br = w.b_re; bi = w.b_im; k = w.scale_factor;
    one = 64'sd1 <<< FRAC;
    re = 0; im = 0;
    r = '0;
    case (w.action)
      cau_pkg::OP_ADD: begin re = ar + br; im = ai + bi; end
      cau_pkg::OP_SUB: begin re = ar - br; im = ai - bi; end
      cau_pkg::OP_SCALE: begin re = floor_q(k * ar); im = floor_q(k * ai); end
      cau_pkg::OP_MUL: begin
        re = floor_q(ar * br - ai * bi);
        im = floor_q(ar * bi + ai * br);
      end
      cau_pkg::OP_CONJ: begin re = ar; im = -ai; end
      cau_pkg::OP_MAGSQ: begin re = floor_q(ar * ar + ai * ai); im = 0; end
      cau_pkg::OP_RECIP: begin
        d = ar * ar + ai * ai;
        if (d == 0) r.divide_by_zero = 1'b1;
        else begin
          re = (ar * one * one) / d;
          im = (-ai * one * one) / d;
        end
      end
      default: begin
        d = br * br + bi * bi;
        if (d == 0) r.divide_by_zero = 1'b1;
        else begin
          re = ((ar * br + ai * bi) * one) / d;
          im = ((ai * br - ar * bi) * one) / d;
        end
      end
    endcase
    if (re > 32767) begin re = 32767; r.saturated = 1'b1; end
    if (re < -32768) begin re = -32768; r.saturated = 1'b1; end
    if (im > 32767) begin im = 32767; r.saturated = 1'b1; end
    if (im < -32768) begin im = -32768; r.saturated = 1'b1; end
    r.z_re = re[15:0];
    r.z_im = im[15:0];
    return r;
  endfunction

  // Directed rows; has_expect marks the ones with a typed-in result.
  typedef struct {
    cau_pkg::in_word_t  word;
    bit                 has_expect;
    cau_pkg::out_word_t expect_word;
  } stim_row_t;

  stim_row_t directed[$];

  function automatic stim_row_t row(input cau_pkg::op_t op,
                                    input logic [15:0] ar, ai, br, bi, k,
                                    input bit he, input cau_pkg::out_word_t ex);
    stim_row_t s;
    s.word = '{action: op, a_re: ar, a_im: ai, b_re: br, b_im: bi, scale_factor: k};
    s.has_expect = he;
    s.expect_word = ex;
    return s;
  endfunction

  task automatic build_table();
    cau_pkg::out_word_t nx;
    nx = '0;
    directed.push_back(row(cau_pkg::OP_ADD, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 0, 1,
                           '{16'h7fff, 16'h8000, 1'b1, 1'b0}));
    directed.push_back(row(cau_pkg::OP_ADD, 16'h0100, 16'hff00, 16'h0200, 16'h0001, 0, 1,
                           '{16'h0300, 16'hff01, 1'b0, 1'b0}));
    directed.push_back(row(cau_pkg::OP_SUB, 16'h8000, 16'h7fff, 16'h7fff, 16'h8000, 0, 1,
                           '{16'h8000, 16'h7fff, 1'b1, 1'b0}));
    directed.push_back(row(cau_pkg::OP_SUB, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 0, 1,
                           '{16'h0000, 16'h0000, 1'b0, 1'b0}));
    directed.push_back(row(cau_pkg::OP_SCALE, 16'h8000, 16'h7fff, 0, 0, 16'h8000, 0, nx));
    directed.push_back(row(cau_pkg::OP_SCALE, 16'hffff, 16'h0001, 0, 0, 16'h0001, 0, nx));
    directed.push_back(row(cau_pkg::OP_SCALE, 16'h1234, 16'hedcb, 0, 0, 16'h0100, 1,
                           '{16'h1234, 16'hedcb, 1'b0, 1'b0}));
    directed.push_back(row(cau_pkg::OP_MUL, 16'h8000, 16'h8000, 16'h8000, 16'h8000,
                           0, 0, nx));
    directed.push_back(row(cau_pkg::OP_MUL, 16'h7fff, 16'h8000, 16'h8000, 16'h7fff,
                           0, 0, nx));
    directed.push_back(row(cau_pkg::OP_MUL, 16'hffff, 16'h0001, 16'h0001, 16'hffff,
                           0, 0, nx));
    directed.push_back(row(cau_pkg::OP_CONJ, 16'h8000, 16'h8000, 0, 0, 0, 1,
                           '{16'h8000, 16'h7fff, 1'b1, 1'b0}));
    directed.push_back(row(cau_pkg::OP_CONJ, 16'h7fff, 16'h7fff, 16'hffff, 16'hffff,
                           16'hffff, 1, '{16'h7fff, 16'h8001, 1'b0, 1'b0}));
    directed.push_back(row(cau_pkg::OP_MAGSQ, 16'h8000, 16'h8000, 0, 0, 0, 1,
                           '{16'h7fff, 16'h0000, 1'b1, 1'b0}));
    directed.push_back(row(cau_pkg::OP_MAGSQ, 16'h0001, 16'h0000, 0, 0, 0, 0, nx));
    directed.push_back(row(cau_pkg::OP_RECIP, 0, 0, 16'h1111, 16'h2222, 16'h3333, 1,
                           '{16'h0000, 16'h0000, 1'b0, 1'b1}));
    directed.push_back(row(cau_pkg::OP_RECIP, 16'h0100, 16'h0000, 0, 0, 0, 1,
                           '{16'h0100, 16'h0000, 1'b0, 1'b0}));
    directed.push_back(row(cau_pkg::OP_RECIP, 16'h0001, 16'h0000, 0, 0, 0, 1,
                           '{16'h7fff, 16'h0000, 1'b1, 1'b0}));
    directed.push_back(row(cau_pkg::OP_RECIP, 16'h8000, 16'h7fff, 0, 0, 0, 0, nx));
    directed.push_back(row(cau_pkg::OP_DIV, 16'h7fff, 16'h7fff, 0, 0, 0, 1,
                           '{16'h0000, 16'h0000, 1'b0, 1'b1}));
    directed.push_back(row(cau_pkg::OP_DIV, 16'h8000, 16'h8000, 16'h0001, 16'h0000, 0, 1,
                           '{16'h8000, 16'h8000, 1'b1, 1'b0}));
    directed.push_back(row(cau_pkg::OP_DIV, 16'h0300, 16'hfd00, 16'h0100, 16'h0000, 0, 1,
                           '{16'h0300, 16'hfd00, 1'b0, 1'b0}));
    directed.push_back(row(cau_pkg::OP_DIV, 16'hff01, 16'h00ff, 16'h8000, 16'h8000,
                           0, 0, nx));
  endtask

  function automatic logic [15:0] rand_operand();
    case ($urandom_range(0, 5))
      0: return 16'(32'h8000 + $urandom_range(0, 3));
      1: return 16'(32'h7fff - $urandom_range(0, 3));
      2: return 16'($urandom_range(0, 8) - 4);
      3: return 16'($urandom_range(0, 1024) - 512);
      default: return 16'($urandom());
    endcase
  endfunction

  task automatic send_word(input cau_pkg::in_word_t w);
    int gap;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 10);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_results.push_back(complex_result(w));
  endtask

  // Sink: stall in bursts until the quiet tail.
  int stall_left = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        stall_left <= $urandom_range(0, 9);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cau_pkg::out_word_t exp_w;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result word %h", out_data);
        n_fail++;
      end else begin
        exp_w = pending_results.pop_front();
        if (out_data.z_re !== exp_w.z_re) begin
          $error("z_re expected %h actual %h", exp_w.z_re, out_data.z_re);
          n_fail++;
        end
        if (out_data.z_im !== exp_w.z_im) begin
          $error("z_im expected %h actual %h", exp_w.z_im, out_data.z_im);
          n_fail++;
        end
        if (out_data.saturated !== exp_w.saturated) begin
          $error("saturated expected %b actual %b", exp_w.saturated, out_data.saturated);
          n_fail++;
        end
        if (out_data.divide_by_zero !== exp_w.divide_by_zero) begin
          $error("divide_by_zero expected %b actual %b",
                 exp_w.divide_by_zero, out_data.divide_by_zero);
          n_fail++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    cau_pkg::in_word_t w;
    build_table();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (directed[i]) begin
      send_word(directed[i].word);
      // Typed-in rows replace the predicted word with the table's.
      if (directed[i].has_expect) begin
        void'(pending_results.pop_back());
        pending_results.push_back(directed[i].expect_word);
      end
    end
    for (int n = 0; n < N_RANDOM; n++) begin
      if (n == N_RANDOM - 300) quiet = 1'b1;
      w.action = cau_pkg::op_t'($urandom_range(0, 7));
      w.a_re = rand_operand();
      w.a_im = rand_operand();
      w.b_re = rand_operand();
      w.b_im = rand_operand();
      w.scale_factor = rand_operand();
      // Hit zero divisors now and then.
      if ($urandom_range(0, 19) == 0) begin
        if (w.action == cau_pkg::OP_RECIP) begin w.a_re = 0; w.a_im = 0; end
        else begin w.b_re = 0; w.b_im = 0; end
      end
      send_word(w);
    end
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (n_fail == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule

### sim.f
hw/rtl/cau_pkg.sv
hw/rtl/complex_arithmetic_unit.sv
dv/complex_arithmetic_unit_tb.sv
